// File: rtl/r30led_pkg.sv
package r30led_pkg;

  // Field widths of the two channels and of the configuration register.
  localparam int OPCODE_W   = 2;
  localparam int INDEX_W    = 8;
  localparam int COLOR_W    = 8;
  localparam int RING_LEN_W = 9;

  // Stored entry: cell bit on top of a Q4.12 level.
  localparam int LEVEL_W = 16;
  localparam int ENTRY_W = LEVEL_W + 1;
  localparam int CODE_W  = 4;

  localparam logic [RING_LEN_W-1:0] RING_LEN_RESET = 9'd215;
  localparam logic [RING_LEN_W-1:0] RING_LEN_MIN   = 9'd3;

  // Blur weights in Q0.16 and the rounding offset.
  localparam logic [13:0] W_SIDE     = 14'd15860;
  localparam logic [14:0] W_MID      = 15'd26149;
  localparam logic [32:0] BLUR_ROUND = 33'd32768;

  // Color scale factors, applied as level * K >> 15.
  localparam logic [7:0] K_RED   = 8'd232;
  localparam logic [7:0] K_GREEN = 8'd67;
  localparam logic [7:0] K_BLUE  = 8'd23;

  // Level codes of 5 and above belong to a live cell.
  localparam logic [CODE_W-1:0] CODE_LIVE_MIN = 4'd5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } opcode_e;

  typedef struct packed {
    logic               no_change;
    logic               cell_state;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } result_t;

  // Rule 30 on a neighborhood {left, self, right}: returns the level code,
  // which is the level's integer part. A new live cell gets c+4.
  function automatic logic [CODE_W-1:0] rule_code(input logic [2:0] nbh);
    logic [CODE_W-1:0] code;
    case (nbh) inside
      [3'd1:3'd4]: code = {1'b0, nbh} + 4'd4;
      3'd0:        code = 4'd1;
      default:     code = {1'b0, nbh} - 4'd3;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/r30led_in_if.sv
interface r30led_in_if;
  import r30led_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [INDEX_W-1:0]  cell_index;
  logic                cell_value;

  modport source (output valid, output opcode, output cell_index, output cell_value,
                  input ready);
  modport sink (input valid, input opcode, input cell_index, input cell_value,
                output ready);
endinterface

// File: rtl/r30led_out_if.sv
interface r30led_out_if;
  import r30led_pkg::*;

  logic               valid;
  logic               ready;
  logic               no_change;
  logic               cell_state;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, output no_change, output cell_state, output red,
                  output green, output blue, input ready);
  modport sink (input valid, input no_change, input cell_state, input red,
                input green, input blue, output ready);
endinterface

// File: rtl/rule30_ring_led_effect.sv
// Load and read: the input transfer issues the entry read, S_LOAD or S_READ
// fills the result register and S_PUSH hands it to the output register.
// Advance: a rule walk over the ring of n cells, then a commit walk and
// BLUR_PASSES blur walks; a no-change advance ends after the rule walk.
// One item is in work at a time; each blur step runs through S_BL_X and
// S_BL_Y, and the entry memory has one write port and one read port.
// After reset a clearing pass writes all MAX_CELLS entries, one per cycle.
module rule30_ring_led_effect #(
  parameter int MAX_CELLS   = 256,
  parameter int BLUR_PASSES = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [r30led_pkg::RING_LEN_W-1:0] cfg_wdata_i,
  r30led_in_if.sink                        in_i,
  r30led_out_if.source                     out_o
);
  import r30led_pkg::*;

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 3);
  localparam int PW = $clog2(BLUR_PASSES + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_READ, S_RULE, S_COMMIT,
    S_BL_A0, S_BL_A1, S_BL_A2, S_BL_X, S_BL_Y, S_PUSH
  } state_e;

  state_e               state_q, state_d;
  logic [RING_LEN_W-1:0] ring_len_q, ring_len_d;
  logic [CW-1:0]        rc_q, rc_d, ac_q, ac_d;
  logic                 av_q, av_d, chg_q, chg_d, wv_q, wv_d;
  logic [1:0]           win_q, win_d;
  logic [AW-1:0]        wa_q, wa_d, idx_q, idx_d, i_q, i_d;
  logic                 val_q, val_d, mbit_q, mbit_d;
  logic [PW-1:0]        pass_q, pass_d;
  logic [LEVEL_W-1:0]   lft_q, lft_d, mid_q, mid_d, first_q, first_d;
  result_t              res_q, res_d, out_res_q, out_res_d;
  logic                 out_valid_q, out_valid_d;

  logic [CW-1:0]        n_c, nm1, np1;
  logic                 in_acc, in_rng;
  logic                 ring_we, ring_re, scr_we, scr_re;
  logic [AW-1:0]        ring_waddr, ring_raddr, scr_waddr, scr_raddr;
  logic [ENTRY_W-1:0]   ring_wdata, ring_rdata;
  logic [CODE_W-1:0]    scr_wdata, scr_rdata, code;
  logic                 blur_en, chg_now;
  logic [LEVEL_W-1:0]   blur_rgt, blur_level;
  logic [COLOR_W-1:0]   red, green, blue;

  // Cell bit and level per entry.
  r30led_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CELLS)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Scratch level codes of the generation being built.
  r30led_ram #(.WIDTH(CODE_W), .DEPTH(MAX_CELLS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .re_i    (scr_re),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  assign blur_rgt = (CW'(i_q) == nm1) ? first_q : ring_rdata[LEVEL_W-1:0];

  r30led_blur u_blur (
    .clk_i   (clk_i),
    .en_i    (blur_en),
    .lft_i   (lft_q),
    .mid_i   (mid_q),
    .rgt_i   (blur_rgt),
    .level_o (blur_level)
  );

  r30led_colour u_colour (
    .level_i (ring_rdata[LEVEL_W-1:0]),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue)
  );

  // Ring length in use, clamped to 3..MAX_CELLS.
  always_comb begin
    if (ring_len_q < RING_LEN_MIN) begin
      n_c = CW'(3);
    end else if (32'(ring_len_q) > MAX_CELLS) begin
      n_c = CW'(MAX_CELLS);
    end else begin
      n_c = CW'(ring_len_q);
    end
  end
  assign nm1 = n_c - CW'(1);
  assign np1 = n_c + CW'(1);

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_rng     = (32'(in_i.cell_index) < MAX_CELLS);

  assign out_o.valid      = out_valid_q;
  assign out_o.no_change  = out_res_q.no_change;
  assign out_o.cell_state = out_res_q.cell_state;
  assign out_o.red        = out_res_q.red;
  assign out_o.green      = out_res_q.green;
  assign out_o.blue       = out_res_q.blue;

  // Sequencer: next state, memory accesses and register updates.
  always_comb begin
    state_d     = state_q;
    ring_len_d  = cfg_we_i ? cfg_wdata_i : ring_len_q;
    rc_d        = rc_q;
    ac_d        = ac_q;
    av_d        = av_q;
    chg_d       = chg_q;
    wv_d        = wv_q;
    win_d       = win_q;
    wa_d        = wa_q;
    idx_d       = idx_q;
    i_d         = i_q;
    val_d       = val_q;
    mbit_d      = mbit_q;
    pass_d      = pass_q;
    lft_d       = lft_q;
    mid_d       = mid_q;
    first_d     = first_q;
    res_d       = res_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ring_we     = 1'b0;
    ring_waddr  = '0;
    ring_wdata  = '0;
    ring_re     = 1'b0;
    ring_raddr  = '0;
    scr_we      = 1'b0;
    scr_waddr   = '0;
    scr_wdata   = '0;
    scr_re      = 1'b0;
    scr_raddr   = '0;
    blur_en     = 1'b0;
    code        = '0;
    chg_now     = chg_q;

    case (state_q)
      // Zero every entry once after reset.
      S_CLEAR: begin
        ring_we    = 1'b1;
        ring_waddr = AW'(rc_q);
        rc_d       = rc_q + CW'(1);
        if (rc_q == CW'(MAX_CELLS - 1)) begin
          rc_d    = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          idx_d = AW'(in_i.cell_index);
          val_d = in_i.cell_value;
          res_d = '0;
          case (in_i.opcode)
            OP_LOAD: begin
              ring_re    = in_rng;
              ring_raddr = AW'(in_i.cell_index);
              state_d    = in_rng ? S_LOAD : S_PUSH;
            end
            OP_READ: begin
              ring_re    = in_rng;
              ring_raddr = AW'(in_i.cell_index);
              state_d    = in_rng ? S_READ : S_PUSH;
            end
            OP_ADVANCE: begin
              rc_d    = '0;
              av_d    = 1'b0;
              chg_d   = 1'b0;
              state_d = S_RULE;
            end
            default: state_d = S_PUSH;
          endcase
        end
      end

      // Read-modify-write: replace the cell bit, keep the level.
      S_LOAD: begin
        ring_we          = 1'b1;
        ring_waddr       = idx_q;
        ring_wdata       = {val_q, ring_rdata[LEVEL_W-1:0]};
        res_d.cell_state = val_q;
        state_d          = S_PUSH;
      end

      S_READ: begin
        res_d.cell_state = ring_rdata[LEVEL_W];
        res_d.red        = red;
        res_d.green      = green;
        res_d.blue       = blue;
        state_d          = S_PUSH;
      end

      // Rule walk: reads last, 0..n-1, then 0 again; a three-bit window
      // slides over the arriving cell bits.
      S_RULE: begin
        av_d = 1'b0;
        if (rc_q <= np1) begin
          ring_re = 1'b1;
          if (rc_q == '0) begin
            ring_raddr = AW'(nm1);
          end else if (rc_q == np1) begin
            ring_raddr = '0;
          end else begin
            ring_raddr = AW'(rc_q - CW'(1));
          end
          rc_d = rc_q + CW'(1);
          av_d = 1'b1;
          ac_d = rc_q;
        end
        if (av_q) begin
          win_d = {win_q[0], ring_rdata[LEVEL_W]};
          if (ac_q >= CW'(2)) begin
            code      = rule_code({win_q, ring_rdata[LEVEL_W]});
            scr_we    = 1'b1;
            scr_waddr = AW'(ac_q - CW'(2));
            scr_wdata = code;
            chg_now   = chg_q | ((code >= CODE_LIVE_MIN) != win_q[0]);
            chg_d     = chg_now;
            if (ac_q == np1) begin
              if (chg_now) begin
                rc_d    = '0;
                wv_d    = 1'b0;
                state_d = S_COMMIT;
              end else begin
                res_d.no_change = 1'b1;
                state_d         = S_PUSH;
              end
            end
          end
        end
      end

      // Copy the new generation in: cell bit and fresh level per entry.
      S_COMMIT: begin
        if (wv_q) begin
          ring_we    = 1'b1;
          ring_waddr = wa_q;
          ring_wdata = {scr_rdata >= CODE_LIVE_MIN, scr_rdata, 12'b0};
        end
        if (rc_q < n_c) begin
          scr_re    = 1'b1;
          scr_raddr = AW'(rc_q);
          wa_d      = AW'(rc_q);
          wv_d      = 1'b1;
          rc_d      = rc_q + CW'(1);
        end else begin
          wv_d    = 1'b0;
          pass_d  = '0;
          state_d = S_BL_A0;
        end
      end

      // Blur pass setup: old last level, then cells 0 and 1.
      S_BL_A0: begin
        ring_re    = 1'b1;
        ring_raddr = AW'(nm1);
        state_d    = S_BL_A1;
      end

      S_BL_A1: begin
        lft_d      = ring_rdata[LEVEL_W-1:0];
        ring_re    = 1'b1;
        ring_raddr = '0;
        state_d    = S_BL_A2;
      end

      S_BL_A2: begin
        mid_d      = ring_rdata[LEVEL_W-1:0];
        mbit_d     = ring_rdata[LEVEL_W];
        ring_re    = 1'b1;
        ring_raddr = AW'(1);
        i_d        = '0;
        state_d    = S_BL_X;
      end

      S_BL_X: begin
        blur_en = 1'b1;
        state_d = S_BL_Y;
      end

      // Write the blurred level in place; it becomes the next cell's left.
      S_BL_Y: begin
        ring_we    = 1'b1;
        ring_waddr = i_q;
        ring_wdata = {mbit_q, blur_level};
        lft_d      = blur_level;
        if (i_q == '0) begin
          first_d = blur_level;
        end
        mid_d  = ring_rdata[LEVEL_W-1:0];
        mbit_d = ring_rdata[LEVEL_W];
        if (CW'(i_q) + CW'(2) <= nm1) begin
          ring_re    = 1'b1;
          ring_raddr = AW'(CW'(i_q) + CW'(2));
        end
        if (CW'(i_q) == nm1) begin
          if (pass_q == PW'(BLUR_PASSES - 1)) begin
            state_d = S_PUSH;
          end else begin
            pass_d  = pass_q + PW'(1);
            state_d = S_BL_A0;
          end
        end else begin
          i_d     = i_q + AW'(1);
          state_d = S_BL_X;
        end
      end

      // Hand the result to the output register once it is free.
      S_PUSH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ring_len_q  <= RING_LEN_RESET;
      rc_q        <= '0;
      ac_q        <= '0;
      av_q        <= 1'b0;
      chg_q       <= 1'b0;
      wv_q        <= 1'b0;
      win_q       <= '0;
      wa_q        <= '0;
      idx_q       <= '0;
      i_q         <= '0;
      val_q       <= 1'b0;
      mbit_q      <= 1'b0;
      pass_q      <= '0;
      lft_q       <= '0;
      mid_q       <= '0;
      first_q     <= '0;
      res_q       <= '0;
      out_res_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ring_len_q  <= ring_len_d;
      rc_q        <= rc_d;
      ac_q        <= ac_d;
      av_q        <= av_d;
      chg_q       <= chg_d;
      wv_q        <= wv_d;
      win_q       <= win_d;
      wa_q        <= wa_d;
      idx_q       <= idx_d;
      i_q         <= i_d;
      val_q       <= val_d;
      mbit_q      <= mbit_d;
      pass_q      <= pass_d;
      lft_q       <= lft_d;
      mid_q       <= mid_d;
      first_q     <= first_d;
      res_q       <= res_d;
      out_res_q   <= out_res_d;
      out_valid_q <= out_valid_d;
    end
  end

  // One item at a time: no transfer right after an accepted one.
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input accepted while an item is in work");

  // Generation and blur writes stay inside the ring in use.
  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_we && (state_q == S_COMMIT || state_q == S_BL_Y)) |-> (CW'(ring_waddr) <= nm1))
    else $error("ring write beyond the ring length");

  // The pass counter never runs past the last blur pass.
  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_q <= PW'(BLUR_PASSES - 1))
    else $error("blur pass counter out of range");

  // A blur step always completes with its write-back in the next cycle.
  a_blur_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BL_X) |=> (state_q == S_BL_Y && ring_we))
    else $error("blur step without write-back");

endmodule

// File: rtl/r30led_ram.sv
module r30led_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; the read data holds
  // until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/r30led_blur.sv
module r30led_blur (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [r30led_pkg::LEVEL_W-1:0] lft_i,
  input  logic [r30led_pkg::LEVEL_W-1:0] mid_i,
  input  logic [r30led_pkg::LEVEL_W-1:0] rgt_i,
  output logic [r30led_pkg::LEVEL_W-1:0] level_o
);
  import r30led_pkg::*;

  logic [LEVEL_W:0] side_sum;
  logic [30:0]      side_d, side_q;
  logic [30:0]      mid_d, mid_q;
  logic [32:0]      total;
  logic [16:0]      rounded;

  // Both weighted products, registered when en_i is high.
  assign side_sum = {1'b0, lft_i} + {1'b0, rgt_i};
  assign side_d   = {14'b0, side_sum} * {17'b0, W_SIDE};
  assign mid_d    = {15'b0, mid_i} * {16'b0, W_MID};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      mid_q  <= mid_d;
    end
  end

  // Combinational: add the registered products, round half up, saturate.
  assign total   = {2'b0, side_q} + {2'b0, mid_q} + BLUR_ROUND;
  assign rounded = total[32:16];
  assign level_o = rounded[16] ? {LEVEL_W{1'b1}} : rounded[LEVEL_W-1:0];

endmodule

// File: rtl/r30led_colour.sv
module r30led_colour (
  input  logic [r30led_pkg::LEVEL_W-1:0] level_i,
  output logic [r30led_pkg::COLOR_W-1:0] red_o,
  output logic [r30led_pkg::COLOR_W-1:0] green_o,
  output logic [r30led_pkg::COLOR_W-1:0] blue_o
);
  import r30led_pkg::*;

  // Level times K over 2^15, truncated, then clipped to one byte.
  function automatic logic [COLOR_W-1:0] scale(input logic [LEVEL_W-1:0] lv,
                                               input logic [7:0] k);
    logic [23:0] prod;
    logic [8:0]  shifted;
    prod    = {8'b0, lv} * {16'b0, k};
    shifted = prod[23:15];
    return shifted[8] ? 8'hFF : shifted[7:0];
  endfunction

  assign red_o   = scale(level_i, K_RED);
  assign green_o = scale(level_i, K_GREEN);
  assign blue_o  = scale(level_i, K_BLUE);

endmodule

// File: tb/rule30_ring_led_effect_tb.sv
module rule30_ring_led_effect_tb;
  import r30led_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int CELLS      = 256;
  localparam int PASSES     = 3;
  localparam int RANDOM_ITEMS = 500;
  localparam int ITEMS_PER_PHASE = 36;
  localparam int QUIET_CYCLES = 2100;
  localparam int LIMIT_CYCLES = 10_000_000;

  // Blur weights in Q0.16 and the color scale factors.
  localparam longint unsigned SIDE_WT = 15860;
  localparam longint unsigned MID_WT  = 26149;
  localparam longint unsigned RED_K   = 232;
  localparam longint unsigned GREEN_K = 67;
  localparam longint unsigned BLUE_K  = 23;

  // The one opcode that the package leaves without a name.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam result_t RSP_ZERO      = '0;
  localparam result_t RSP_NO_CHANGE = '{no_change: 1'b1, default: '0};
  localparam result_t RSP_LIVE      = '{cell_state: 1'b1, default: '0};

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [INDEX_W-1:0]  idx;
    logic                val;
    logic                fixed_rsp;
    result_t             want;
  } stim_row_t;

  // Directed rows, run at the reset ring length of 215.
  localparam int DIR_ROWS = 23;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_READ,    8'd0,   1'b0, 1'b1, RSP_ZERO},
    '{OP_READ,    8'd255, 1'b0, 1'b1, RSP_ZERO},
    '{OP_ADVANCE, 8'd0,   1'b0, 1'b1, RSP_NO_CHANGE},
    '{OP_UNUSED,  8'd255, 1'b1, 1'b1, RSP_ZERO},
    '{OP_LOAD,    8'd0,   1'b1, 1'b1, RSP_LIVE},
    '{OP_LOAD,    8'd255, 1'b1, 1'b1, RSP_LIVE},
    '{OP_LOAD,    8'd107, 1'b1, 1'b1, RSP_LIVE},
    '{OP_LOAD,    8'd214, 1'b0, 1'b1, RSP_ZERO},
    '{OP_ADVANCE, 8'd0,   1'b0, 1'b0, RSP_ZERO},
    '{OP_READ,    8'd0,   1'b0, 1'b0, RSP_ZERO},
    '{OP_READ,    8'd1,   1'b0, 1'b0, RSP_ZERO},
    '{OP_READ,    8'd214, 1'b0, 1'b0, RSP_ZERO},
    '{OP_READ,    8'd213, 1'b0, 1'b0, RSP_ZERO},
    '{OP_READ,    8'd107, 1'b0, 1'b0, RSP_ZERO},
    '{OP_READ,    8'd108, 1'b0, 1'b0, RSP_ZERO},
    '{OP_READ,    8'd255, 1'b0, 1'b0, RSP_ZERO},
    '{OP_ADVANCE, 8'd0,   1'b1, 1'b0, RSP_ZERO},
    '{OP_READ,    8'd106, 1'b0, 1'b0, RSP_ZERO},
    '{OP_READ,    8'd2,   1'b1, 1'b0, RSP_ZERO},
    '{OP_UNUSED,  8'd0,   1'b0, 1'b1, RSP_ZERO},
    '{OP_LOAD,    8'd255, 1'b0, 1'b1, RSP_ZERO},
    '{OP_READ,    8'd255, 1'b0, 1'b0, RSP_ZERO},
    '{OP_READ,    8'd128, 1'b0, 1'b0, RSP_ZERO}
  };

  // Ring length settings of the random phases, out-of-range values among them.
  localparam int LEN_STEPS = 15;
  localparam logic [RING_LEN_W-1:0] LEN_PLAN [LEN_STEPS] = '{
    9'd3, 9'd256, 9'd0, 9'd8, 9'd511, 9'd2, 9'd16, 9'd257, 9'd5, 9'd1,
    9'd40, 9'd215, 9'd11, 9'd4, 9'd100
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [RING_LEN_W-1:0] cfg_wdata;

  r30led_in_if  req_ch ();
  r30led_out_if rsp_ch ();

  rule30_ring_led_effect i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_ch),
    .out_o       (rsp_ch)
  );

  // Shadow copy of the ring, its levels and the length register.
  logic [CELLS-1:0]         cell_bits;
  logic [LEVEL_W-1:0]       level_mem [CELLS];
  logic [RING_LEN_W-1:0]    ring_len_reg;

  result_t responses_due [$];
  int      mismatch_count = 0;
  int      src_idle_pct = 0;
  int      rsp_stall_pct = 0;

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  function automatic int unsigned ring_span();
    int unsigned n;
    n = ring_len_reg;
    if (n < 3) n = 3;
    if (n > CELLS) n = CELLS;
    return n;
  endfunction

  // One smoothing step: weighted sum, rounded half up, saturated to 16 bits.
  function automatic logic [LEVEL_W-1:0] blur_step(input logic [LEVEL_W-1:0] lft,
                                                   input logic [LEVEL_W-1:0] mid,
                                                   input logic [LEVEL_W-1:0] rgt);
    longint unsigned acc;
    acc = SIDE_WT * lft + MID_WT * mid + SIDE_WT * rgt;
    acc = (acc + 64'd32768) >> 16;
    if (acc > 65535) acc = 65535;
    return acc[LEVEL_W-1:0];
  endfunction

  function automatic logic [COLOR_W-1:0] color_byte(input logic [LEVEL_W-1:0] lv,
                                                    input longint unsigned k);
    longint unsigned acc;
    acc = (k * lv) >> 15;
    if (acc > 255) acc = 255;
    return acc[COLOR_W-1:0];
  endfunction

  // One rule 30 generation plus in-place blur; returns 1 when no cell would change.
  function automatic bit advance_ring();
    int unsigned n, lft, rgt, code;
    logic [2:0] nbh;
    logic [CELLS-1:0] nxt;
    logic [LEVEL_W-1:0] fresh [CELLS];
    bit moved;
    n = ring_span();
    moved = 1'b0;
    nxt = '0;
    for (int i = 0; i < n; i++) begin
      lft = (i == 0) ? n - 1 : i - 1;
      rgt = (i == n - 1) ? 0 : i + 1;
      nbh = {cell_bits[lft], cell_bits[i], cell_bits[rgt]};
      if (nbh >= 3'd1 && nbh <= 3'd4) begin
        nxt[i] = 1'b1;
        code = nbh + 4;
      end else begin
        nxt[i] = 1'b0;
        code = (nbh == 3'd0) ? 1 : nbh - 3;
      end
      fresh[i] = LEVEL_W'(code << 12);
      if (nxt[i] != cell_bits[i]) moved = 1'b1;
    end
    if (!moved) return 1'b1;
    for (int i = 0; i < n; i++) begin
      level_mem[i] = fresh[i];
      cell_bits[i] = nxt[i];
    end
    // Each cell sees its left neighbor already smoothed in this pass.
    for (int p = 0; p < PASSES; p++) begin
      for (int i = 0; i < n; i++) begin
        lft = (i == 0) ? n - 1 : i - 1;
        rgt = (i == n - 1) ? 0 : i + 1;
        level_mem[i] = blur_step(level_mem[lft], level_mem[i], level_mem[rgt]);
      end
    end
    return 1'b0;
  endfunction

  // Applies one item to the shadow state and returns the response it causes.
  function automatic result_t led_response(input logic [OPCODE_W-1:0] op,
                                           input logic [INDEX_W-1:0] idx,
                                           input logic val);
    result_t rsp;
    rsp = '0;
    case (op)
      OP_LOAD: begin
        cell_bits[idx] = val;
        rsp.cell_state = val;
      end
      OP_ADVANCE: begin
        rsp.no_change = advance_ring();
      end
      OP_READ: begin
        rsp.cell_state = cell_bits[idx];
        rsp.red = color_byte(level_mem[idx], RED_K);
        rsp.green = color_byte(level_mem[idx], GREEN_K);
        rsp.blue = color_byte(level_mem[idx], BLUE_K);
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // Drives one item, waits for its transfer and queues the response it should cause.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic val, input bit fixed_rsp, input result_t given,
                           output result_t predicted);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.cell_index <= idx;
    req_ch.cell_value <= val;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    predicted = led_response(op, idx, val);
    responses_due.push_back(fixed_rsp ? given : predicted);
  endtask

  // Holds the request channel idle until every queued response has arrived.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_ring_length(input logic [RING_LEN_W-1:0] value);
    drain_responses();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    ring_len_reg = value;
  endtask

  function automatic logic [INDEX_W-1:0] pick_index(input int unsigned n);
    if ($urandom_range(99) < 80) return INDEX_W'($urandom_range(n - 1));
    return INDEX_W'($urandom_range(255));
  endfunction

  task automatic report_mismatch(input string field, input int want, input int seen);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
    mismatch_count++;
  endtask

  // Response side: random stalls, and each response transfer checked in order.
  always @(posedge clk_i) begin : rsp_check
    result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (responses_due.size() == 0) begin
        $display("%0t: response with none pending, expected none, actual %0d/%0d/%0d/%0d/%0d",
                 $time, rsp_ch.no_change, rsp_ch.cell_state, rsp_ch.red, rsp_ch.green,
                 rsp_ch.blue);
        mismatch_count++;
      end else begin
        want = responses_due.pop_front();
        if (rsp_ch.no_change !== want.no_change)
          report_mismatch("no_change", want.no_change, rsp_ch.no_change);
        if (rsp_ch.cell_state !== want.cell_state)
          report_mismatch("cell_state", want.cell_state, rsp_ch.cell_state);
        if (rsp_ch.red !== want.red) report_mismatch("red", want.red, rsp_ch.red);
        if (rsp_ch.green !== want.green) report_mismatch("green", want.green, rsp_ch.green);
        if (rsp_ch.blue !== want.blue) report_mismatch("blue", want.blue, rsp_ch.blue);
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  initial begin : stimulus
    int random_sent, n, pick;
    logic [INDEX_W-1:0] idx;
    result_t rsp;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_LOAD;
    req_ch.cell_index = '0;
    req_ch.cell_value = 1'b0;
    rsp_ch.ready = 1'b0;
    cell_bits = '0;
    for (int i = 0; i < CELLS; i++) level_mem[i] = '0;
    ring_len_reg = 9'd215;
    random_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: fixed responses where obvious, shadow state elsewhere.
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(DIRECTED[r].op, DIRECTED[r].idx, DIRECTED[r].val, DIRECTED[r].fixed_rsp,
                DIRECTED[r].want, rsp);
    end

    // Random phases, each at its own ring length and idling pattern.
    for (int phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
      write_ring_length(LEN_PLAN[phase % LEN_STEPS]);
      case (phase % 5)
        1: begin
          src_idle_pct = 52;
          rsp_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          rsp_stall_pct = 52;
        end
        3: begin
          src_idle_pct = 21;
          rsp_stall_pct = 21;
        end
        default: begin
          src_idle_pct = 0;
          rsp_stall_pct = 0;
        end
      endcase
      n = ring_span();

      // On short rings an alternating pattern sometimes, which rule 30 leaves
      // alone when the ring length is even.
      if (n <= 16 && $urandom_range(2) == 0) begin
        for (int i = 0; i < n; i++) begin
          send_item(OP_LOAD, INDEX_W'(i), i[0], 1'b0, RSP_ZERO, rsp);
          random_sent++;
        end
        send_item(OP_ADVANCE, pick_index(n), 1'($urandom), 1'b0, RSP_ZERO, rsp);
        random_sent++;
      end

      // Seed a few live cells so that advances have work to do.
      repeat ($urandom_range(5, 1)) begin
        send_item(OP_LOAD, INDEX_W'($urandom_range(n - 1)), 1'b1, 1'b0, RSP_ZERO, rsp);
        random_sent++;
      end

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2 && phase % 3 == 1) drain_responses();
        pick = $urandom_range(99);
        idx = pick_index(n);
        if (pick < 25) begin
          send_item(OP_ADVANCE, idx, 1'($urandom), 1'b0, RSP_ZERO, rsp);
          // A stuck ring gets reseeded, as a host would do.
          if (rsp.no_change) begin
            repeat ($urandom_range(3, 1)) begin
              send_item(OP_LOAD, INDEX_W'($urandom_range(n - 1)), 1'b1, 1'b0, RSP_ZERO,
                        rsp);
              random_sent++;
            end
          end
        end else if (pick < 47) begin
          send_item(OP_LOAD, idx, 1'($urandom), 1'b0, RSP_ZERO, rsp);
        end else if (pick < 96) begin
          send_item(OP_READ, idx, 1'($urandom), 1'b0, RSP_ZERO, rsp);
        end else begin
          send_item(OP_UNUSED, INDEX_W'($urandom_range(255)), 1'($urandom), 1'b0, RSP_ZERO,
                    rsp);
        end
        random_sent++;
      end
    end

    drain_responses();
    repeat (QUIET_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && responses_due.size() == 0) begin
      $display("rule30_ring_led_effect verification clean");
    end else begin
      $display("rule30_ring_led_effect verification failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("rule30_ring_led_effect verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/r30led_pkg.sv
rtl/r30led_in_if.sv
rtl/r30led_out_if.sv
rtl/r30led_ram.sv
rtl/r30led_blur.sv
rtl/r30led_colour.sv
rtl/rule30_ring_led_effect.sv
tb/rule30_ring_led_effect_tb.sv
